[src/hla_pkg.sv]
// Shared types and constants for the Hough line accumulator.
// No dependencies; imported by hla_dist_bin and hough_line_accumulator_core.
`default_nettype none

package hla_pkg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_V_ROW,
        S_V_MUL,
        S_V_SUM,
        S_V_QMUL,
        S_V_BIN,
        S_V_UPD,
        S_P_SCAN,
        S_P_DRAIN,
        S_P_WRD,
        S_P_WWR,
        S_P_UNMARK,
        S_CLEAR
    } t_state;

    typedef enum logic [1:0] {
        ACT_VOTE,
        ACT_PEAK,
        ACT_LOAD,
        ACT_CLEAR
    } t_action;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_OFFSET_X    = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd2;
    localparam logic [2:0] REG_SLOPE_FIRST = 3'd3;
    localparam logic [2:0] REG_SLOPE_STEP  = 3'd4;
    localparam logic [2:0] REG_DIST_MIN    = 3'd5;
    localparam logic [2:0] REG_INV_STEP    = 3'd6;
    localparam logic [2:0] REG_ANGLE_USED  = 3'd7;

    localparam logic MODE_ANGLE = 1'b1;

    localparam int COORD_W     = 24;
    localparam int SLOPE_W     = 16;
    localparam int TRIG_W      = 16;
    localparam int INV_W       = 24;
    localparam int USED_W      = 9;
    localparam int CFG_W       = 24;
    localparam int FRAC_SLOPE  = 8;
    localparam int FRAC_TRIG   = 14;
    localparam int MAG_W       = 56;
    localparam int SPLIT       = 26;
    localparam int SHIFT_SLOPE = 32;
    localparam int SHIFT_ANGLE = 38;

endpackage

`default_nettype wire

[src/hough_line_accumulator_core.sv]
// Top level of the Hough line accumulator: control sequencer and memories.
// Depends on hla_pkg and instantiates hla_dist_bin.
`default_nettype none

// Channel    Ports                                         Beat taken when
// command    i_start, o_busy, i_action .. i_cosine         i_start && !o_busy
// result     o_valid, o_peak_count/angle/distance          o_valid (one cycle)
// config     i_cfg_we, i_cfg_index, i_cfg_data             i_cfg_we
//
// After reset a clearing pass over every entry zeroes the count
// and mark memories; o_busy stays high meanwhile, configuration writes still land.
// A vote steps through each row in use (table read, multiply, sum, bin
// multiply, bin check, count read-modify-write if the bin is in range),
// one memory port per memory. A load writes one sine/cosine table entry;
// a clear zeroes every entry. Find peak scans the rows in use, one memory entry
// a cycle, each pass, marks window cells (read, then write), and clears marks.
// Every command gives one result beat on the cycle after it finishes; the
// receiver cannot stall, and the next command may be taken in that same cycle.

module hough_line_accumulator_core #(
    parameter int ANGLE_BINS = 256,
    parameter int DIST_BINS  = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic [1:0]                         i_action,
    input  wire logic signed [hla_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [hla_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                               i_remove,
    input  wire logic [3:0]                         i_ignore_count,
    input  wire logic [4:0]                         i_window,
    input  wire logic [7:0]                         i_angle_index,
    input  wire logic signed [hla_pkg::TRIG_W-1:0]  i_sine,
    input  wire logic signed [hla_pkg::TRIG_W-1:0]  i_cosine,
    output logic                                    o_valid,
    output logic [15:0]                             o_peak_count,
    output logic [7:0]                              o_peak_angle,
    output logic [7:0]                              o_peak_distance,
    input  wire logic                               i_cfg_we,
    input  wire logic [2:0]                         i_cfg_index,
    input  wire logic [hla_pkg::CFG_W-1:0]          i_cfg_data
);
    import hla_pkg::*;

    localparam int AB    = $clog2(ANGLE_BINS);
    localparam int RW    = AB + 1;
    localparam int DB    = $clog2(DIST_BINS);
    localparam int CELLS = ANGLE_BINS * DIST_BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int DX_W  = COORD_W + 1;
    localparam int SW    = SLOPE_W + AB + 2;
    localparam int P1_W  = SW + DX_W;
    localparam int P2_W  = TRIG_W + DX_W;

    // Configuration registers.
    logic                      r_mode;
    logic signed [COORD_W-1:0] r_off_x;
    logic signed [COORD_W-1:0] r_off_y;
    logic signed [SLOPE_W-1:0] r_slope_first;
    logic signed [SLOPE_W-1:0] r_slope_step;
    logic signed [COORD_W-1:0] r_dist_min;
    logic [INV_W-1:0]          r_inv;
    logic [USED_W-1:0]         r_used;

    // Memories and their registered read data.
    logic [COUNT_BITS-1:0] r_cnt_mem [CELLS];
    logic                  r_mark_mem [CELLS];
    logic [TRIG_W-1:0]     r_sin_mem [ANGLE_BINS];
    logic [TRIG_W-1:0]     r_cos_mem [ANGLE_BINS];
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_mark_q;
    logic signed [TRIG_W-1:0] r_sin_q;
    logic signed [TRIG_W-1:0] r_cos_q;

    // Control state.
    t_state r_state, n_state;
    logic [AB-1:0] r_a, n_a;
    logic [DB-1:0] r_d, n_d;
    logic          r_sv, n_sv;
    logic          r_out_valid, n_out_valid;

    // Working registers of the current command.
    logic signed [DX_W-1:0]    r_dx, n_dx;
    logic signed [DX_W-1:0]    r_dy, n_dy;
    logic                      r_remove, n_remove;
    logic [3:0]                r_ign, n_ign;
    logic [3:0]                r_half, n_half;
    logic [3:0]                r_k, n_k;
    logic [RW-1:0]             r_rows, n_rows;
    logic signed [SW-1:0]      r_s, n_s;
    logic signed [P1_W-1:0]    r_p1, n_p1;
    logic signed [P2_W-1:0]    r_p2, n_p2;
    logic [MAG_W-1:0]          r_mag, n_mag;
    logic                      r_neg, n_neg;
    logic [DB-1:0]             r_bin, n_bin;
    logic [COUNT_BITS-1:0]     r_best, n_best;
    logic                      r_found, n_found;
    logic [AB-1:0]             r_pa, n_pa;
    logic [DB-1:0]             r_pd, n_pd;
    logic [AB-1:0]             r_sa, n_sa;
    logic [DB-1:0]             r_sd, n_sd;
    logic [AB-1:0]             r_alo, n_alo;
    logic [AB-1:0]             r_ahi, n_ahi;
    logic [DB-1:0]             r_dlo, n_dlo;
    logic [DB-1:0]             r_dhi, n_dhi;
    logic [15:0]               r_out_count, n_out_count;
    logic [7:0]                r_out_angle, n_out_angle;
    logic [7:0]                r_out_dist, n_out_dist;

    // Combinational helpers.
    logic                      c_accept;
    logic [RW-1:0]             c_rows;
    logic [AB-1:0]             c_ma;
    logic [DB-1:0]             c_md;
    logic [AW-1:0]             c_addr;
    logic                      cnt_we;
    logic [COUNT_BITS-1:0]     cnt_wd;
    logic                      mark_we;
    logic                      mark_wd;
    logic                      tab_we;
    logic signed [SW-1:0]      c_m1a;
    logic signed [P1_W-1:0]    c_prod1;
    logic signed [P2_W-1:0]    c_prod2;
    logic signed [MAG_W-1:0]   c_dist;
    logic                      bin_ok;
    logic [DB-1:0]             bin_idx;
    logic                      c_hit;
    logic                      c_row_done;
    logic                      c_fin;
    logic                      c_fin_peak;
    logic                      c_last_d;
    logic                      c_last_row;
    logic                      c_last_all;

    assign o_busy          = (r_state != S_IDLE);
    assign c_accept        = i_start && !o_busy;
    assign o_valid         = r_out_valid;
    assign o_peak_count    = r_out_count;
    assign o_peak_angle    = r_out_angle;
    assign o_peak_distance = r_out_dist;

    // Configuration port: writes land at any time, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ANGLE;
            r_off_x       <= '0;
            r_off_y       <= '0;
            r_slope_first <= '0;
            r_slope_step  <= SLOPE_W'(256);
            r_dist_min    <= '0;
            r_inv         <= INV_W'(65536);
            r_used        <= USED_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:        r_mode        <= i_cfg_data[0];
                REG_OFFSET_X:    r_off_x       <= i_cfg_data[COORD_W-1:0];
                REG_OFFSET_Y:    r_off_y       <= i_cfg_data[COORD_W-1:0];
                REG_SLOPE_FIRST: r_slope_first <= i_cfg_data[SLOPE_W-1:0];
                REG_SLOPE_STEP:  r_slope_step  <= i_cfg_data[SLOPE_W-1:0];
                REG_DIST_MIN:    r_dist_min    <= i_cfg_data[COORD_W-1:0];
                REG_INV_STEP:    r_inv         <= i_cfg_data[INV_W-1:0];
                REG_ANGLE_USED:  r_used        <= i_cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    // Single address for both big memories; rows are laid out back to back.
    assign c_addr = AW'(AW'(c_ma) * AW'(DIST_BINS) + AW'(c_md));

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[c_addr] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[c_addr] <= mark_wd;
        end
        r_mark_q <= r_mark_mem[c_addr];
    end

    // Trig tables are read at the current row every cycle.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_sin_mem[AB'(i_angle_index)] <= i_sine;
            r_cos_mem[AB'(i_angle_index)] <= i_cosine;
        end
        r_sin_q <= r_sin_mem[r_a];
        r_cos_q <= r_cos_mem[r_a];
    end

    // Distance arithmetic for the vote path.
    assign c_m1a   = (r_mode == MODE_ANGLE) ? SW'(r_cos_q) : r_s;
    assign c_prod1 = c_m1a * r_dx;
    assign c_prod2 = r_sin_q * r_dy;

    always_comb begin
        if (r_mode == MODE_ANGLE) begin
            c_dist = MAG_W'(r_p1) + MAG_W'(r_p2) - (MAG_W'(r_dist_min) <<< FRAC_TRIG);
        end else begin
            c_dist = (MAG_W'(r_dy) <<< FRAC_SLOPE) - MAG_W'(r_p1)
                   - (MAG_W'(r_dist_min) <<< FRAC_SLOPE);
        end
    end

    hla_dist_bin #(
        .DIST_BINS (DIST_BINS)
    ) u_dist_bin (
        .i_clk   (i_clk),
        .i_mag   (r_mag),
        .i_neg   (r_neg),
        .i_angle (r_mode),
        .i_inv   (r_inv),
        .o_ok    (bin_ok),
        .o_bin   (bin_idx)
    );

    assign c_rows = (32'(r_used) > 32'(ANGLE_BINS)) ? RW'(ANGLE_BINS) : RW'(r_used);

    assign c_last_d   = (r_d == DB'(DIST_BINS - 1));
    assign c_last_row = ((RW'(r_a) + RW'(1)) == r_rows);
    assign c_last_all = (r_a == AB'(ANGLE_BINS - 1));

    // A scanned entry replaces the peak only when strictly larger, so the
    // first largest bin in row-major order wins.
    assign c_hit = r_sv && !r_mark_q && (!r_found || (r_cnt_q > r_best));

    always_comb begin
        int v_half;
        int v_pa;
        int v_pd;
        int v_rows;
        int v_lo;
        int v_hi;

        v_half = int'(r_half);
        v_pa   = 0;
        v_pd   = 0;
        v_rows = int'(r_rows);
        v_lo   = 0;
        v_hi   = 0;

        n_state     = r_state;
        n_a         = r_a;
        n_d         = r_d;
        n_sv        = 1'b0;
        n_out_valid = 1'b0;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_remove    = r_remove;
        n_ign       = r_ign;
        n_half      = r_half;
        n_k         = r_k;
        n_rows      = r_rows;
        n_s         = r_s;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_best      = c_hit ? r_cnt_q : r_best;
        n_found     = r_found || c_hit;
        n_pa        = c_hit ? r_sa : r_pa;
        n_pd        = c_hit ? r_sd : r_pd;
        n_sa        = r_a;
        n_sd        = r_d;
        n_alo       = r_alo;
        n_ahi       = r_ahi;
        n_dlo       = r_dlo;
        n_dhi       = r_dhi;
        n_out_count = r_out_count;
        n_out_angle = r_out_angle;
        n_out_dist  = r_out_dist;

        c_ma       = r_a;
        c_md       = r_d;
        cnt_we     = 1'b0;
        cnt_wd     = '0;
        mark_we    = 1'b0;
        mark_wd    = 1'b0;
        tab_we     = 1'b0;
        c_row_done = 1'b0;
        c_fin      = 1'b0;
        c_fin_peak = 1'b0;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                cnt_we  = 1'b1;
                mark_we = 1'b1;
                if (c_last_d) begin
                    n_d = '0;
                    if (c_last_all) begin
                        if (r_state == S_CLEAR) begin
                            c_fin = 1'b1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_a = r_a + AB'(1);
                    end
                end else begin
                    n_d = r_d + DB'(1);
                end
            end

            S_IDLE: begin
                if (c_accept) begin
                    n_rows = c_rows;
                    n_a    = '0;
                    n_d    = '0;
                    unique case (t_action'(i_action))
                        ACT_VOTE: begin
                            n_dx     = DX_W'(i_point_x) - DX_W'(r_off_x);
                            n_dy     = DX_W'(i_point_y) - DX_W'(r_off_y);
                            n_s      = SW'(r_slope_first);
                            n_remove = i_remove;
                            if (c_rows == '0) begin
                                c_fin = 1'b1;
                            end else begin
                                n_state = S_V_ROW;
                            end
                        end
                        ACT_PEAK: begin
                            n_ign   = i_ignore_count;
                            n_half  = i_window[4:1];
                            n_k     = '0;
                            n_pa    = '0;
                            n_pd    = '0;
                            n_best  = '0;
                            n_found = 1'b0;
                            if (c_rows == '0) begin
                                c_fin = 1'b1;
                            end else begin
                                n_state = S_P_SCAN;
                            end
                        end
                        ACT_LOAD: begin
                            tab_we = (32'(i_angle_index) < 32'(ANGLE_BINS));
                            c_fin  = 1'b1;
                        end
                        ACT_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            S_V_ROW: begin
                n_state = S_V_MUL;
            end

            S_V_MUL: begin
                n_p1    = c_prod1;
                n_p2    = c_prod2;
                n_state = S_V_SUM;
            end

            S_V_SUM: begin
                n_neg   = c_dist[MAG_W-1];
                n_mag   = c_dist[MAG_W-1] ? MAG_W'(-c_dist) : MAG_W'(c_dist);
                n_state = S_V_QMUL;
            end

            S_V_QMUL: begin
                n_state = S_V_BIN;
            end

            S_V_BIN: begin
                if (bin_ok) begin
                    c_md    = bin_idx;
                    n_bin   = bin_idx;
                    n_state = S_V_UPD;
                end else begin
                    c_row_done = 1'b1;
                end
            end

            S_V_UPD: begin
                // Count read issued in the bin cycle is valid now.
                c_md   = r_bin;
                cnt_we = 1'b1;
                if (r_remove) begin
                    cnt_wd = (r_cnt_q != '0) ? r_cnt_q - COUNT_BITS'(1) : r_cnt_q;
                end else begin
                    cnt_wd = (r_cnt_q != '1) ? r_cnt_q + COUNT_BITS'(1) : r_cnt_q;
                end
                c_row_done = 1'b1;
            end

            S_P_SCAN: begin
                n_sv = 1'b1;
                if (c_last_d) begin
                    n_d = '0;
                    if (c_last_row) begin
                        n_state = S_P_DRAIN;
                    end else begin
                        n_a = r_a + AB'(1);
                    end
                end else begin
                    n_d = r_d + DB'(1);
                end
            end

            S_P_DRAIN: begin
                // The last scanned beat is folded into the n_ values above.
                if (n_found && (r_k < r_ign)) begin
                    v_pa = int'(n_pa);
                    v_pd = int'(n_pd);
                    if (r_mode == MODE_ANGLE) begin
                        v_lo = v_pa;
                        v_hi = v_pa;
                    end else begin
                        v_lo = (v_pa > v_half) ? v_pa - v_half : 0;
                        v_hi = (v_pa + v_half > v_rows - 1) ? v_rows - 1 : v_pa + v_half;
                    end
                    n_alo = AB'(v_lo);
                    n_ahi = AB'(v_hi);
                    n_a   = AB'(v_lo);
                    v_lo  = (v_pd > v_half) ? v_pd - v_half : 0;
                    v_hi  = (v_pd + v_half > DIST_BINS - 1) ? DIST_BINS - 1 : v_pd + v_half;
                    n_dlo = DB'(v_lo);
                    n_dhi = DB'(v_hi);
                    n_d   = DB'(v_lo);
                    n_state = S_P_WRD;
                end else begin
                    n_a     = '0;
                    n_d     = '0;
                    n_state = S_P_UNMARK;
                end
            end

            S_P_WRD: begin
                n_state = S_P_WWR;
            end

            S_P_WWR: begin
                // Only bins that hold votes are masked.
                mark_we = (r_cnt_q != '0);
                mark_wd = 1'b1;
                n_state = S_P_WRD;
                if (r_d == r_dhi) begin
                    n_d = r_dlo;
                    if (r_a == r_ahi) begin
                        n_k     = r_k + 4'd1;
                        n_found = 1'b0;
                        n_best  = '0;
                        n_a     = '0;
                        n_d     = '0;
                        n_state = S_P_SCAN;
                    end else begin
                        n_a = r_a + AB'(1);
                    end
                end else begin
                    n_d = r_d + DB'(1);
                end
            end

            S_P_UNMARK: begin
                mark_we = 1'b1;
                if (c_last_d) begin
                    n_d = '0;
                    if (c_last_row) begin
                        c_fin      = 1'b1;
                        c_fin_peak = 1'b1;
                    end else begin
                        n_a = r_a + AB'(1);
                    end
                end else begin
                    n_d = r_d + DB'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (c_row_done) begin
            n_s = r_s + SW'(r_slope_step);
            if (c_last_row) begin
                c_fin = 1'b1;
            end else begin
                n_a     = r_a + AB'(1);
                n_state = S_V_ROW;
            end
        end

        if (c_fin) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out_count = c_fin_peak ? 16'(r_best) : '0;
            n_out_angle = c_fin_peak ? 8'(r_pa) : '0;
            n_out_dist  = c_fin_peak ? 8'(r_pd) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_a         <= '0;
            r_d         <= '0;
            r_sv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_d         <= n_d;
            r_sv        <= n_sv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_remove    <= n_remove;
        r_ign       <= n_ign;
        r_half      <= n_half;
        r_k         <= n_k;
        r_rows      <= n_rows;
        r_s         <= n_s;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_bin       <= n_bin;
        r_best      <= n_best;
        r_found     <= n_found;
        r_pa        <= n_pa;
        r_pd        <= n_pd;
        r_sa        <= n_sa;
        r_sd        <= n_sd;
        r_alo       <= n_alo;
        r_ahi       <= n_ahi;
        r_dlo       <= n_dlo;
        r_dhi       <= n_dhi;
        r_out_count <= n_out_count;
        r_out_angle <= n_out_angle;
        r_out_dist  <= n_out_dist;
    end

endmodule

`default_nettype wire

[src/hla_dist_bin.sv]
// Distance bin unit: scales a distance magnitude by the reciprocal bin width.
// Depends on hla_pkg. Products are registered; the bin decision follows them.
`default_nettype none

module hla_dist_bin #(
    parameter int DIST_BINS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic [hla_pkg::MAG_W-1:0] i_mag,
    input  wire logic                      i_neg,
    input  wire logic                      i_angle,
    input  wire logic [hla_pkg::INV_W-1:0] i_inv,
    output logic                           o_ok,
    output logic [$clog2(DIST_BINS)-1:0]   o_bin
);
    import hla_pkg::*;

    localparam int DB    = $clog2(DIST_BINS);
    localparam int HI_W  = MAG_W - SPLIT;
    localparam int PH_W  = HI_W + INV_W;
    localparam int PL_W  = SPLIT + INV_W;
    localparam int SUM_W = PH_W + 1;

    logic [PH_W-1:0]  r_prod_hi;
    logic [PL_W-1:0]  r_prod_lo;
    logic             r_neg;
    logic             r_angle;
    logic [SUM_W-1:0] c_sum;
    logic [SUM_W-1:0] c_q;

    // The magnitude is split in two so each product stays a modest multiplier.
    always_ff @(posedge i_clk) begin
        r_prod_hi <= i_mag[MAG_W-1:SPLIT] * i_inv;
        r_prod_lo <= i_mag[SPLIT-1:0] * i_inv;
        r_neg     <= i_neg;
        r_angle   <= i_angle;
    end

    always_comb begin
        c_sum = SUM_W'(r_prod_hi) + SUM_W'(r_prod_lo >> SPLIT);
        c_q   = r_angle ? (c_sum >> (SHIFT_ANGLE - SPLIT)) : (c_sum >> (SHIFT_SLOPE - SPLIT));
        // A negative distance lands only when it truncates to bin zero.
        o_ok  = !(r_neg && (c_q != '0)) && (c_q < SUM_W'(DIST_BINS));
        o_bin = DB'(c_q);
    end

endmodule

`default_nettype wire
